/* hw/rtl/asc_pkg.sv */
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants for the ARX sponge byte cipher
// Control word layout, microcode program, datapath control groups and
// configuration register indexes.
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned NWORDS    = 16;
  localparam int unsigned PC_W      = 4;
  localparam int unsigned TAG_IDX_W = 4;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0] INIT_MULT = 64'h7477697468617369;
  localparam logic [7:0]        NEWLINE   = 8'h0A;
  localparam logic [TAG_IDX_W-1:0] TAG_LAST = 4'd15;

  // input op codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_FIN   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE0 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE1 = 3'd6;

  // microcode addresses
  localparam logic [PC_W-1:0] PC_FETCH    = 4'd0;
  localparam logic [PC_W-1:0] PC_START    = 4'd1;
  localparam logic [PC_W-1:0] PC_FIN      = 4'd2;
  localparam logic [PC_W-1:0] PC_DATA     = 4'd3;
  localparam logic [PC_W-1:0] PC_PERM     = 4'd4;
  localparam logic [PC_W-1:0] PC_PERM_END = 4'd11;
  localparam logic [PC_W-1:0] PC_POST     = 4'd12;
  localparam logic [PC_W-1:0] PC_TAG      = 4'd13;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_STOP = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_ABSORB,
    DP_FLIP,
    DP_QSTEP
  } dp_op_e;

  typedef enum logic [1:0] {
    ROT32,
    ROT25,
    ROT16,
    ROT11
  } rot_e;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_DATA,
    EM_TAG
  } emit_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_DISPATCH,
    J_ALWAYS,
    J_NL,
    J_ROUND,
    J_NOFIN,
    J_TAG
  } jmp_e;

  typedef enum logic [1:0] {
    PU_KEEP,
    PU_RUN,
    PU_IDLE
  } phupd_e;

  // one microcode control word
  typedef struct packed {
    dp_op_e          dp_op;
    logic            diag;   // 1: diagonal step, 0: column step
    logic            half;   // 0: a+=b, d=rot(d^a); 1: c+=d, b=rot(b^c)
    rot_e            rot;
    emit_e           emit;
    jmp_e            jmp;
    phupd_e          ph;
    logic [PC_W-1:0] tgt;
  } uc_t;

  // sequencer -> datapath
  typedef struct packed {
    dp_op_e               op;
    logic                 diag;
    logic                 half;
    rot_e                 rot;
    logic [TAG_IDX_W-1:0] tag_idx;
    logic                 byte_we;
  } dp_ctrl_t;

  // sequencer -> output register
  typedef struct packed {
    logic en;
    logic tag;
    logic stop;
    logic last;
  } emit_t;

  typedef struct packed {
    logic                  mode_encrypt;
    logic [3:0][WORD_W-1:0] key;
    logic [1:0][WORD_W-1:0] nonce;
  } cfg_t;

  function automatic logic [WORD_W-1:0] init_word(input logic [3:0] idx);
    init_word = {60'd0, idx} * INIT_MULT;
  endfunction

  function automatic uc_t mk_qstep(input logic diag, input logic half, input rot_e rot,
                                   input jmp_e jmp);
    uc_t w;
    w = '{dp_op: DP_QSTEP, diag: diag, half: half, rot: rot, emit: EM_NONE,
          jmp: jmp, ph: PU_KEEP, tgt: PC_PERM};
    mk_qstep = w;
  endfunction

  // microcode program
  function automatic uc_t ucode(input logic [PC_W-1:0] pc);
    uc_t w;
    w = '{dp_op: DP_NOP, diag: 1'b0, half: 1'b0, rot: ROT32, emit: EM_NONE,
          jmp: J_ALWAYS, ph: PU_KEEP, tgt: PC_FETCH};
    case (pc)
      PC_FETCH: begin
        w.jmp = J_DISPATCH;
      end
      PC_START: begin
        w.dp_op = DP_LOAD;
        w.ph    = PU_RUN;
        w.tgt   = PC_PERM;
      end
      PC_FIN: begin
        w.dp_op = DP_FLIP;
        w.tgt   = PC_PERM;
      end
      PC_DATA: begin
        w.dp_op = DP_ABSORB;
        w.emit  = EM_DATA;
        w.jmp   = J_NL;
        w.tgt   = PC_FETCH;
      end
      PC_PERM:         w = mk_qstep(1'b0, 1'b0, ROT32, J_NEXT);
      PC_PERM + 4'd1:  w = mk_qstep(1'b0, 1'b1, ROT25, J_NEXT);
      PC_PERM + 4'd2:  w = mk_qstep(1'b0, 1'b0, ROT16, J_NEXT);
      PC_PERM + 4'd3:  w = mk_qstep(1'b0, 1'b1, ROT11, J_NEXT);
      PC_PERM + 4'd4:  w = mk_qstep(1'b1, 1'b0, ROT32, J_NEXT);
      PC_PERM + 4'd5:  w = mk_qstep(1'b1, 1'b1, ROT25, J_NEXT);
      PC_PERM + 4'd6:  w = mk_qstep(1'b1, 1'b0, ROT16, J_NEXT);
      PC_PERM_END:     w = mk_qstep(1'b1, 1'b1, ROT11, J_ROUND);
      PC_POST: begin
        w.jmp = J_NOFIN;
        w.tgt = PC_FETCH;
      end
      PC_TAG: begin
        w.emit = EM_TAG;
        w.jmp  = J_TAG;
        w.ph   = PU_IDLE;
        w.tgt  = PC_FETCH;
      end
      default: begin
      end
    endcase
    ucode = w;
  endfunction

endpackage

/* hw/rtl/asc_dpath.sv */
// ----------------------------------------------------------------------------
// asc_dpath: sponge state datapath
// Sixteen 64-bit state words, four G lanes doing one add-xor-rotate line
// per cycle, plus load, absorb, flip and tag byte selection.
// ----------------------------------------------------------------------------
module asc_dpath (
  input  logic             clk_i,
  input  asc_pkg::dp_ctrl_t ctrl_i,
  input  asc_pkg::cfg_t    cfg_i,
  input  logic [7:0]       byte_i,
  output logic [7:0]       y_byte_o,
  output logic             nl_o,
  output logic [7:0]       tag_byte_o
);
  import asc_pkg::*;

  logic [WORD_W-1:0] st_q [NWORDS];
  logic [WORD_W-1:0] st_d [NWORDS];
  logic [7:0]        byte_q;
  logic [WORD_W-1:0] lane_x [4];
  logic [WORD_W-1:0] lane_z [4];
  logic [WORD_W-1:0] tag_word;

  // G lanes: k picks a column, diag shifts rows 1..3 by 1..3 places
  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [WORD_W-1:0] a_w, b_w, c_w, d_w, x_w, y_w, z_w, sum_w, mix_w, rot_w;
    assign a_w = st_q[k];
    assign b_w = ctrl_i.diag ? st_q[4 + ((k + 1) & 3)]  : st_q[4 + k];
    assign c_w = ctrl_i.diag ? st_q[8 + ((k + 2) & 3)]  : st_q[8 + k];
    assign d_w = ctrl_i.diag ? st_q[12 + ((k + 3) & 3)] : st_q[12 + k];
    assign x_w = ctrl_i.half ? c_w : a_w;
    assign y_w = ctrl_i.half ? d_w : b_w;
    assign z_w = ctrl_i.half ? b_w : d_w;
    assign sum_w = x_w + y_w;
    assign mix_w = z_w ^ sum_w;
    always_comb begin
      case (ctrl_i.rot)
        ROT32:   rot_w = {mix_w[31:0], mix_w[63:32]};
        ROT25:   rot_w = {mix_w[24:0], mix_w[63:25]};
        ROT16:   rot_w = {mix_w[15:0], mix_w[63:16]};
        ROT11:   rot_w = {mix_w[10:0], mix_w[63:11]};
        default: rot_w = mix_w;
      endcase
    end
    assign lane_z[k] = rot_w;
    assign lane_x[k] = sum_w;
  end

  always_comb begin
    for (int i = 0; i < NWORDS; i++) begin
      st_d[i] = st_q[i];
    end
    case (ctrl_i.op)
      DP_LOAD: begin
        for (int i = 0; i < NWORDS; i++) begin
          st_d[i] = init_word(4'(i));
        end
        for (int i = 0; i < 4; i++) begin
          st_d[i] = cfg_i.key[i];
        end
        st_d[4] = cfg_i.nonce[0];
        st_d[5] = cfg_i.nonce[1];
      end
      DP_ABSORB: begin
        if (cfg_i.mode_encrypt) begin
          st_d[0] = st_q[0] ^ {56'd0, byte_q};
        end else begin
          st_d[0] = {st_q[0][63:8], byte_q};
        end
      end
      DP_FLIP: begin
        st_d[0] = st_q[0] ^ 64'd1;
      end
      DP_QSTEP: begin
        for (int j = 0; j < 4; j++) begin
          if (!ctrl_i.half) begin
            st_d[j]      = lane_x[j];
            st_d[12 + j] = ctrl_i.diag ? lane_z[(j + 1) & 3] : lane_z[j];
          end else begin
            st_d[8 + j]  = ctrl_i.diag ? lane_x[(j + 2) & 3] : lane_x[j];
            st_d[4 + j]  = ctrl_i.diag ? lane_z[(j + 3) & 3] : lane_z[j];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NWORDS; i++) begin
      st_q[i] <= st_d[i];
    end
    if (ctrl_i.byte_we) begin
      byte_q <= byte_i;
    end
  end

  assign y_byte_o = st_q[0][7:0] ^ byte_q;
  assign nl_o     = !cfg_i.mode_encrypt && (y_byte_o == NEWLINE);

  assign tag_word   = ctrl_i.tag_idx[3] ? (st_q[6] ^ st_q[7]) : (st_q[4] ^ st_q[5]);
  assign tag_byte_o = tag_word[{ctrl_i.tag_idx[2:0], 3'b000} +: 8];

endmodule

/* hw/rtl/asc_useq.sv */
// ----------------------------------------------------------------------------
// asc_useq: microcode sequencer
// Step counter over the control ROM, round and tag counters, phase and the
// dispatch of input words.
// ----------------------------------------------------------------------------
module asc_useq #(
  parameter int unsigned DOUBLE_ROUNDS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_op_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  input  logic              nl_i,
  output asc_pkg::dp_ctrl_t dp_ctrl_o,
  output asc_pkg::emit_t    emit_o
);
  import asc_pkg::*;

  localparam int unsigned RND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(DOUBLE_ROUNDS - 1);

  logic [PC_W-1:0]      pc_q, pc_d;
  logic [RND_W-1:0]     rnd_q, rnd_d;
  logic [TAG_IDX_W-1:0] tag_q, tag_d;
  phase_e               phase_q, phase_d;
  logic                 fin_q, fin_d;
  uc_t                  uc;
  logic                 adv;
  logic                 accept;
  logic                 nl_hit;

  always_comb begin
    uc      = ucode(pc_q);
    adv     = (uc.emit == EM_NONE) || out_free_i;
    accept  = (uc.jmp == J_DISPATCH) && in_valid_i;
    nl_hit  = (uc.jmp == J_NL) && nl_i;
    pc_d    = adv ? pc_q + 4'd1 : pc_q;
    rnd_d   = rnd_q;
    tag_d   = tag_q;
    phase_d = phase_q;
    fin_d   = fin_q;
    case (uc.jmp)
      J_NEXT: begin
      end
      J_DISPATCH: begin
        pc_d = PC_FETCH;
        if (in_valid_i) begin
          fin_d = (in_op_i == OP_FIN);
          case (in_op_i)
            OP_START: pc_d = PC_START;
            OP_DATA:  if (phase_q == PH_RUN) pc_d = PC_DATA;
            OP_FIN:   if (phase_q == PH_RUN) pc_d = PC_FIN;
            default:  pc_d = PC_FETCH;
          endcase
        end
      end
      J_ALWAYS: pc_d = uc.tgt;
      J_NL: begin
        if (adv && nl_i) begin
          pc_d    = uc.tgt;
          phase_d = PH_STOP;
        end
      end
      J_ROUND: begin
        if (rnd_q == RND_LAST) begin
          rnd_d = '0;
        end else begin
          rnd_d = rnd_q + RND_W'(1);
          pc_d  = uc.tgt;
        end
      end
      J_NOFIN: if (!fin_q) pc_d = uc.tgt;
      J_TAG: begin
        if (adv) begin
          if (tag_q == TAG_LAST) begin
            tag_d = '0;
            pc_d  = uc.tgt;
          end else begin
            tag_d = tag_q + 4'd1;
            pc_d  = pc_q;
          end
        end
      end
      default: pc_d = PC_FETCH;
    endcase
    if (adv) begin
      case (uc.ph)
        PU_RUN:  phase_d = PH_RUN;
        PU_IDLE: phase_d = PH_IDLE;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= PC_FETCH;
      rnd_q   <= '0;
      tag_q   <= '0;
      phase_q <= PH_IDLE;
      fin_q   <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      rnd_q   <= rnd_d;
      tag_q   <= tag_d;
      phase_q <= phase_d;
      fin_q   <= fin_d;
    end
  end

  assign in_ready_o = (uc.jmp == J_DISPATCH);

  always_comb begin
    dp_ctrl_o.op      = (adv && !nl_hit) ? uc.dp_op : DP_NOP;
    dp_ctrl_o.diag    = uc.diag;
    dp_ctrl_o.half    = uc.half;
    dp_ctrl_o.rot     = uc.rot;
    dp_ctrl_o.tag_idx = tag_q;
    dp_ctrl_o.byte_we = accept;
    emit_o.en   = (uc.emit != EM_NONE) && out_free_i;
    emit_o.tag  = (uc.emit == EM_TAG);
    emit_o.stop = (uc.emit == EM_DATA) && nl_i;
    emit_o.last = (uc.emit == EM_TAG) ? (tag_q == TAG_LAST) : 1'b1;
  end

`ifndef SYNTHESIS
  a_rnd_in_perm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rnd_q != '0) |-> (pc_q >= PC_PERM && pc_q <= PC_PERM_END))
    else $error("round counter live outside permutation");
  a_tag_in_tag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag_q != '0) |-> (pc_q == PC_TAG))
    else $error("tag counter live outside tag step");
  a_start_dispatch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op_i == OP_START) |=> (pc_q == PC_START))
    else $error("start word not dispatched to load");
`endif

endmodule

/* hw/rtl/arx_sponge_byte_cipher_core.sv */
// ----------------------------------------------------------------------------
// arx_sponge_byte_cipher_core: byte-wise duplex sponge cipher
// 16 x 64-bit state, ARX permutation of DOUBLE_ROUNDS double rounds,
// driven by a microcoded sequencer.
//
// channel   dir  tdata                 tuser                     tlast
// s_axis    in   [7:0] data_byte       [1:0] op                  -
// m_axis    out  [7:0] out_byte        [0] is_tag [1] stopped    last
// cfg       in   cfg_data_i by cfg_idx_i, written when cfg_we_i is high
//
// Sequence: the permutation runs one add-xor-rotate line of all four G lanes
//   per cycle, column lines then diagonal lines in each of DOUBLE_ROUNDS double
//   rounds. Start and data words pass fetch, their own step, the permutation
//   and a post step; a data word that stops goes back to fetch instead, and
//   finish then emits 16 tag bytes at the tag step. Ignored words (data or
//   finish outside a running message, op 3) are taken at fetch and stay there.
// Reset clears the sequencer, phase, output valid, key and nonce and sets
//   encrypt mode; the state words are loaded by start before they are read.
// Output stalls hold the sequencer at the emitting step; the output register
//   frees itself in the cycle it is taken.
// ----------------------------------------------------------------------------
module arx_sponge_byte_cipher_core #(
  parameter int unsigned DOUBLE_ROUNDS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [0] is_tag, [1] stopped
  output logic        m_axis_tlast
);
  import asc_pkg::*;

  cfg_t     cfg_q;
  dp_ctrl_t dp_ctrl;
  emit_t    emit;
  logic     out_free;
  logic     nl;
  logic [7:0] y_byte;
  logic [7:0] tag_byte;

  logic       out_valid_q;
  logic [7:0] out_data_q, out_data_d;
  logic [1:0] out_user_q;
  logic       out_last_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode_encrypt: 1'b1, key: '0, nonce: '0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:   cfg_q.mode_encrypt <= cfg_data_i[0];
        CFG_KEY0:   cfg_q.key[0]       <= cfg_data_i;
        CFG_KEY1:   cfg_q.key[1]       <= cfg_data_i;
        CFG_KEY2:   cfg_q.key[2]       <= cfg_data_i;
        CFG_KEY3:   cfg_q.key[3]       <= cfg_data_i;
        CFG_NONCE0: cfg_q.nonce[0]     <= cfg_data_i;
        CFG_NONCE1: cfg_q.nonce[1]     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  asc_useq #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .nl_i       (nl),
    .dp_ctrl_o  (dp_ctrl),
    .emit_o     (emit)
  );

  asc_dpath u_dpath (
    .clk_i      (clk_i),
    .ctrl_i     (dp_ctrl),
    .cfg_i      (cfg_q),
    .byte_i     (s_axis_tdata),
    .y_byte_o   (y_byte),
    .nl_o       (nl),
    .tag_byte_o (tag_byte)
  );

  // output register: free when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    if (emit.tag) begin
      out_data_d = tag_byte;
    end else if (emit.stop) begin
      out_data_d = 8'h00;
    end else begin
      out_data_d = y_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.en) begin
      out_data_q <= out_data_d;
      out_user_q <= {emit.stop, emit.tag};
      out_last_q <= emit.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_stop_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
    else $error("stop word must be a lone, non-tag word");
`endif

endmodule

/* tb/asc_cipher_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_cipher_checker: result predictor and comparator for the sponge cipher
// Follows the config writes and accepted input words, runs its own copy of the
// sponge state and flags every result word that is unexpected or differs.
// ----------------------------------------------------------------------------
module asc_cipher_checker #(
  parameter int unsigned DOUBLE_ROUNDS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  input  logic [1:0]  m_axis_tuser,   // [0] is_tag, [1] stopped
  input  logic        m_axis_tlast,
  output int          pending_o,      // result words still due
  output int          fail_count_o,
  output logic [7:0]  ks_byte_o       // low byte of predicted word 0
);
  import asc_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_tag;
    logic       stopped;
    logic       last;
  } cipher_out_t;

  cipher_out_t due_q[$];
  cipher_out_t due_w;

  logic [63:0] sp [16];
  phase_e      msg_phase;
  logic        mode_enc;
  logic [63:0] key_w [4];
  logic [63:0] nonce_w [2];
  int          n_fail;

  function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

  task automatic g_mix(input int unsigned a, input int unsigned b, input int unsigned c,
                       input int unsigned d);
    sp[a] = sp[a] + sp[b]; sp[d] = rotr(sp[d] ^ sp[a], 32);
    sp[c] = sp[c] + sp[d]; sp[b] = rotr(sp[b] ^ sp[c], 25);
    sp[a] = sp[a] + sp[b]; sp[d] = rotr(sp[d] ^ sp[a], 16);
    sp[c] = sp[c] + sp[d]; sp[b] = rotr(sp[b] ^ sp[c], 11);
  endtask

  task automatic arx_permute();
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      for (int unsigned k = 0; k < 4; k++) g_mix(k, k + 4, k + 8, k + 12);
      for (int unsigned k = 0; k < 4; k++)
        g_mix(k, (k + 1) % 4 + 4, (k + 2) % 4 + 8, (k + 3) % 4 + 12);
    end
  endtask

  task automatic due_push(input logic [7:0] b, input logic tag, input logic stop,
                          input logic last);
    due_q.push_back(cipher_out_t'{out_byte: b, is_tag: tag, stopped: stop, last: last});
  endtask

  // one accepted input word -> expected result words
  task automatic cipher_step(input logic [1:0] op, input logic [7:0] b);
    logic [63:0] kk;
    logic [63:0] t0;
    logic [63:0] t1;
    logic [63:0] sh;
    logic [7:0]  y;
    case (op)
      OP_START: begin
        for (int k = 0; k < 16; k++) begin
          kk = 64'(k);
          sp[k] = kk * INIT_MULT;
        end
        for (int k = 0; k < 4; k++) sp[k] = key_w[k];
        sp[4] = nonce_w[0];
        sp[5] = nonce_w[1];
        arx_permute();
        msg_phase = PH_RUN;
      end
      OP_DATA: begin
        if (msg_phase == PH_RUN) begin
          y = sp[0][7:0] ^ b;
          if (!mode_enc && y == NEWLINE) begin
            // recovered newline ends the stream, state untouched
            due_push(8'h00, 1'b0, 1'b1, 1'b1);
            msg_phase = PH_STOP;
          end else begin
            due_push(y, 1'b0, 1'b0, 1'b1);
            if (mode_enc) sp[0][7:0] = sp[0][7:0] ^ b;
            else sp[0][7:0] = b;
            arx_permute();
          end
        end
      end
      OP_FIN: begin
        if (msg_phase == PH_RUN) begin
          sp[0] = sp[0] ^ 64'd1;
          arx_permute();
          t0 = sp[4] ^ sp[5];
          t1 = sp[6] ^ sp[7];
          for (int k = 0; k < 16; k++) begin
            sh = (k < 8) ? (t0 >> (8 * k)) : (t1 >> (8 * (k - 8)));
            due_push(sh[7:0], 1'b1, 1'b0, k == 15);
          end
          msg_phase = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q.delete();
      for (int i = 0; i < 16; i++) sp[i] = '0;
      for (int i = 0; i < 4; i++) key_w[i] = '0;
      nonce_w[0] = '0;
      nonce_w[1] = '0;
      mode_enc  = 1'b1;
      msg_phase = PH_IDLE;
      n_fail    = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
      ks_byte_o    <= '0;
    end else begin
      // results first: nothing accepted at this edge can show up at it
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_q.size() == 0) begin
          n_fail++;
          $display("%0t checker: result word with none due: expected none,", $time,
                   " got byte=%02h tag=%0b stop=%0b last=%0b",
                   m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast);
        end else begin
          due_w = due_q.pop_front();
          if (due_w.out_byte !== m_axis_tdata || due_w.is_tag !== m_axis_tuser[0] ||
              due_w.stopped !== m_axis_tuser[1] || due_w.last !== m_axis_tlast) begin
            n_fail++;
            $display("%0t checker: mismatch: expected byte=%02h tag=%0b stop=%0b last=%0b,",
                     $time, due_w.out_byte, due_w.is_tag, due_w.stopped, due_w.last,
                     " got byte=%02h tag=%0b stop=%0b last=%0b",
                     m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:   mode_enc   = cfg_data_i[0];
          CFG_KEY0:   key_w[0]   = cfg_data_i;
          CFG_KEY1:   key_w[1]   = cfg_data_i;
          CFG_KEY2:   key_w[2]   = cfg_data_i;
          CFG_KEY3:   key_w[3]   = cfg_data_i;
          CFG_NONCE0: nonce_w[0] = cfg_data_i;
          CFG_NONCE1: nonce_w[1] = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) cipher_step(s_axis_tuser, s_axis_tdata);
      pending_o    <= due_q.size();
      fail_count_o <= n_fail;
      ks_byte_o    <= sp[0][7:0];
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the ARX sponge byte cipher core
// Directed messages over the special cases, then random messages under
// random keys, nonces and modes, with random gaps on input and stalls on
// output. Checking is done by asc_cipher_checker beside the core.
// ----------------------------------------------------------------------------
module tb;
  import asc_pkg::*;

  localparam int unsigned DR            = 6;
  localparam int unsigned SETTLE_CYCLES = 8 * DR + 16;  // a start or a data permute
  localparam int unsigned RANDOM_WORDS  = 460;
  localparam logic [1:0]  OP_RSVD       = 2'd3;         // unused op code
  localparam logic [2:0]  CFG_UNUSED    = 3'd7;         // index with no register

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] data_byte
  logic [1:0]  s_axis_tuser = '0;    // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] out_byte
  logic [1:0]  m_axis_tuser;         // [0] is_tag, [1] stopped
  logic        m_axis_tlast;

  int          pending;
  int          n_fail;
  logic [7:0]  ks_byte;

  // stimulus bookkeeping
  int          n_sent = 0;           // accepted input words
  bit          idle_on = 1'b1;       // random gaps and stalls allowed
  int          stall_left = 0;
  logic [63:0] cfg_vals [7];

  always #1 clk_i = ~clk_i;

  arx_sponge_byte_cipher_core #(
    .DOUBLE_ROUNDS(DR)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  asc_cipher_checker #(
    .DOUBLE_ROUNDS(DR)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pending_o     (pending),
    .fail_count_o  (n_fail),
    .ks_byte_o     (ks_byte)
  );

  // output side: random stall bursts, none once idle_on drops
  always @(posedge clk_i) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 16);
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // One input word. tvalid is left high on return: the caller's next action
  // in the same step either offers a new word or drops tvalid.
  task automatic send_word(input logic [1:0] op, input logic [7:0] b);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // stray word of any op, op 3 included
  task automatic send_noise();
    logic [1:0] op;
    op = 2'($urandom_range(0, 3));
    send_word(op, 8'($urandom_range(0, 255)));
  endtask

  // Ciphertext byte chosen so that decryption recovers a newline. The
  // checker registers its predicted keystream byte as each word is accepted.
  task automatic send_newline_stop();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    send_word(OP_DATA, ks_byte ^ NEWLINE);
  endtask

  // Drop tvalid, wait for every due result, then give the core time to
  // finish a permute that has no result behind it.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // writes all seven registers from cfg_vals, sometimes the unused index too
  task automatic apply_settings();
    logic [2:0] ci;
    ci = CFG_MODE;
    repeat (7) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= ci;
      cfg_data_i <= cfg_vals[ci];
      @(posedge clk_i);
      ci = ci + 3'd1;
    end
    if ($urandom_range(0, 1) == 0) begin
      cfg_idx_i  <= CFG_UNUSED;
      cfg_data_i <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random 64-bit value, extremes now and then
  function automatic logic [63:0] rnd_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // start, a run of data words, maybe a forced stop, mostly a finish
  task automatic run_message(input bit dec);
    int nbytes;
    if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(20, 40);
    else nbytes = $urandom_range(0, 10);
    send_word(OP_START, 8'($urandom_range(0, 255)));
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 11) == 0) send_noise();
      send_word(OP_DATA, 8'($urandom_range(0, 255)));
    end
    if (dec && $urandom_range(0, 2) == 0) begin
      send_newline_stop();
      if ($urandom_range(0, 1) == 0) send_word(OP_DATA, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) != 0) send_word(OP_FIN, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int target;
    int n_msg;
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, reset settings: encrypt, zero key and nonce ---
    send_word(OP_DATA, 8'hFF);        // data before any start: ignored
    send_word(OP_FIN, 8'h00);         // finish while idle: ignored
    send_word(OP_RSVD, 8'hFF);        // unused op: ignored
    send_word(OP_START, 8'h00);
    send_word(OP_DATA, 8'h00);
    send_word(OP_DATA, 8'hFF);
    send_word(OP_DATA, NEWLINE);      // newline plaintext, no stop in encrypt
    send_word(OP_FIN, 8'hFF);

    // --- directed, decrypt with all-ones key and nonce ---
    wait_idle();
    cfg_vals[CFG_MODE]   = 64'hFFFF_FFFF_FFFF_FFFE;  // only bit 0 counts
    cfg_vals[CFG_KEY0]   = '1;
    cfg_vals[CFG_KEY1]   = '1;
    cfg_vals[CFG_KEY2]   = '1;
    cfg_vals[CFG_KEY3]   = '1;
    cfg_vals[CFG_NONCE0] = '1;
    cfg_vals[CFG_NONCE1] = '1;
    apply_settings();
    send_word(OP_START, 8'hFF);
    send_word(OP_DATA, 8'h55);
    send_newline_stop();
    send_word(OP_DATA, 8'hAA);        // stopped: ignored
    send_word(OP_FIN, 8'h00);         // stopped: ignored
    send_word(OP_START, 8'h00);       // restart out of stopped
    send_word(OP_START, 8'h00);       // restart while running
    send_word(OP_DATA, NEWLINE);
    send_word(OP_FIN, 8'h00);

    // --- random phases: new settings, then a few messages ---
    target = n_sent + RANDOM_WORDS;
    while (n_sent < target) begin
      if (n_sent > target - 60) idle_on = 1'b0;  // tail runs flat out
      wait_idle();
      cfg_vals[CFG_MODE] = {$urandom, $urandom};
      for (int i = 0; i < 4; i++) cfg_vals[CFG_KEY0 + i] = rnd_word();
      cfg_vals[CFG_NONCE0] = rnd_word();
      cfg_vals[CFG_NONCE1] = rnd_word();
      apply_settings();
      n_msg = $urandom_range(2, 5);
      for (int m = 0; m < n_msg; m++) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        run_message(!cfg_vals[CFG_MODE][0]);
      end
    end

    wait_idle();
    if (n_fail == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
